FILE: sv/afe_rfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afe_rfe_pkg
// Shared widths, command, kind and status codes, and types for the register
// frame engine.
// ----------------------------------------------------------------------------
package afe_rfe_pkg;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 8;
  localparam int CNT_W  = 6;
  localparam int DATA_W = 16;
  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 5;
  localparam int STAT_W = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RXBYTE = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TX     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WORD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_CRC_ERR   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_COUNT = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDLE_BYTE = 2'd3;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] tx_byte;
    logic [DATA_W-1:0] read_word;
    logic [IDX_W-1:0]  word_index;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic din;
  } crc_ctl_t;

  // one msb-first step of crc-8
  function automatic logic [BYTE_W-1:0] crc_bit(input logic [BYTE_W-1:0] crc,
                                                input logic din);
    return {crc[BYTE_W-2:0], 1'b0} ^ ((crc[BYTE_W-1] ^ din) ? CRC_POLY : 8'h00);
  endfunction

endpackage
`default_nettype wire

FILE: sv/afe_rfe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afe_rfe_if
// Valid/ready channels of the register frame engine: command input and
// result output.
// ----------------------------------------------------------------------------
interface afe_rfe_in_if;
  logic                           valid;
  logic                           ready;
  logic [afe_rfe_pkg::CMD_W-1:0]  command;
  logic [afe_rfe_pkg::ADDR_W-1:0] reg_addr;
  logic [afe_rfe_pkg::CNT_W-1:0]  word_count;
  logic [afe_rfe_pkg::DATA_W-1:0] write_data;
  logic [afe_rfe_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, command, reg_addr, word_count, write_data, rx_byte,
                  input ready);
  modport sink   (input valid, command, reg_addr, word_count, write_data, rx_byte,
                  output ready);
endinterface

interface afe_rfe_out_if;
  logic                           valid;
  logic                           ready;
  logic [afe_rfe_pkg::KIND_W-1:0] result_kind;
  logic [afe_rfe_pkg::BYTE_W-1:0] tx_byte;
  logic [afe_rfe_pkg::DATA_W-1:0] read_word;
  logic [afe_rfe_pkg::IDX_W-1:0]  word_index;
  logic [afe_rfe_pkg::STAT_W-1:0] status;
  logic                           last;

  modport source (output valid, result_kind, tx_byte, read_word, word_index, status, last,
                  input ready);
  modport sink   (input valid, result_kind, tx_byte, read_word, word_index, status, last,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/afe_register_frame_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afe_register_frame_engine_core
// Builds crc-8 protected register write frames and read headers for an analog front
// end and checks read replies, replaying the stored words on a good crc.
// ----------------------------------------------------------------------------
//  channel    dir  handshake    carries
//  in_chan    in   valid/ready  command, reg_addr, word_count, write_data, rx_byte
//  out_chan   out  valid/ready  result_kind, tx_byte, read_word, word_index, status, last
//
// crc runs one bit per cycle: a write covers 24 header and data bits, then four tx bytes
// a read start covers 16 header bits then two header bytes, a reply byte 8 bits
// a good final crc replays the burst, each word fetched then emitted, a status goes out alone
// input is ready only when idle, so a stalled output holds the engine in place
// reset is synchronous active low and leaves the engine idle, no read pending
// ----------------------------------------------------------------------------
module afe_register_frame_engine_core #(
  parameter int MAX_WORDS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  afe_rfe_in_if.sink    in_chan,
  afe_rfe_out_if.source out_chan
);
  import afe_rfe_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [CNT_W:0] MAX_CNT = (CNT_W + 1)'(MAX_WORDS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CRC    = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_TX     = 3'd3;
  localparam logic [2:0] S_STAT   = 3'd4;
  localparam logic [2:0] S_RFETCH = 3'd5;
  localparam logic [2:0] S_RWORD  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic [23:0]       sh_r, sh_nxt;
  logic [4:0]        bits_r, bits_nxt;
  logic [31:0]       emit_r, emit_nxt;
  logic [2:0]        left_r, left_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              reading_r, reading_nxt;
  logic [CNT_W:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]  we_r, we_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;
  logic              final_r, final_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  crc_ctl_t          crc_ctl;
  logic [BYTE_W-1:0] crc;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  logic              accept, out_free, bad_count, word_last;
  logic [BYTE_W-1:0] hdr_w, hdr_r0, hdr_r1;
  logic [CNT_W-1:0]  cnt_m1;

  afe_rfe_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc)
  );

  afe_rfe_wbuf #(
    .DEPTH (MAX_WORDS),
    .AW    (AW),
    .DW    (DATA_W)
  ) u_wbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign cnt_m1    = in_chan.word_count - CNT_W'(1);
  assign hdr_w     = {in_chan.reg_addr[6:0], 1'b1};
  assign hdr_r0    = {in_chan.reg_addr[6:0], 1'b0};
  assign hdr_r1    = {in_chan.reg_addr[7], 2'b00, cnt_m1[4:0]};
  assign bad_count = (in_chan.word_count == '0) || ({1'b0, in_chan.word_count} > MAX_CNT);
  assign word_last = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == we_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sh_nxt        = sh_r;
    bits_nxt      = bits_r;
    emit_nxt      = emit_r;
    left_nxt      = left_r;
    stat_nxt      = stat_r;
    reading_nxt   = reading_r;
    pos_nxt       = pos_r;
    we_nxt        = we_r;
    high_nxt      = high_r;
    final_nxt     = final_r;
    rd_idx_nxt    = rd_idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    crc_ctl       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW:1];
    wr_data       = {high_r, in_chan.rx_byte};
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_chan.command)
            CMD_WRITE: begin
              reading_nxt   = 1'b0;
              sh_nxt        = {hdr_w, in_chan.write_data};
              emit_nxt      = {hdr_w, in_chan.write_data, 8'h00};
              bits_nxt      = 5'd24;
              op_nxt        = CMD_WRITE;
              crc_ctl.clear = 1'b1;
              state_nxt     = S_CRC;
            end
            CMD_READ: begin
              reading_nxt = 1'b0;
              if (bad_count) begin
                stat_nxt  = ST_BAD_COUNT;
                state_nxt = S_STAT;
              end else begin
                sh_nxt        = {hdr_r0, hdr_r1, 8'h00};
                emit_nxt      = {hdr_r0, hdr_r1, 16'h0000};
                bits_nxt      = 5'd16;
                op_nxt        = CMD_READ;
                crc_ctl.clear = 1'b1;
                we_nxt        = in_chan.word_count;
                pos_nxt       = '0;
                high_nxt      = '0;
                reading_nxt   = 1'b1;
                state_nxt     = S_CRC;
              end
            end
            CMD_RXBYTE: begin
              if (!reading_r) begin
                stat_nxt  = ST_IDLE_BYTE;
                state_nxt = S_STAT;
              end else begin
                sh_nxt    = {in_chan.rx_byte, 16'h0000};
                bits_nxt  = 5'd8;
                op_nxt    = CMD_RXBYTE;
                final_nxt = (pos_r == {we_r, 1'b0});
                pos_nxt   = pos_r + (CNT_W + 1)'(1);
                state_nxt = S_CRC;
                if (pos_r == {we_r, 1'b0}) begin
                  reading_nxt = 1'b0;
                end else if (pos_r[0]) begin
                  wr_en = 1'b1;
                end else begin
                  high_nxt = in_chan.rx_byte;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CRC: begin
        crc_ctl.shift = 1'b1;
        crc_ctl.din   = sh_r[23];
        sh_nxt        = {sh_r[22:0], 1'b0};
        bits_nxt      = bits_r - 5'd1;
        if (bits_r == 5'd1) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (op_r)
          CMD_WRITE: begin
            emit_nxt  = {emit_r[31:8], crc};
            left_nxt  = 3'd4;
            state_nxt = S_TX;
          end
          CMD_READ: begin
            left_nxt  = 3'd2;
            state_nxt = S_TX;
          end
          default: begin
            if (!final_r) begin
              state_nxt = S_IDLE;
            end else if (crc != '0) begin
              stat_nxt  = ST_CRC_ERR;
              state_nxt = S_STAT;
            end else begin
              rd_idx_nxt = '0;
              state_nxt  = S_RFETCH;
            end
          end
        endcase
      end
      S_TX: begin
        if (out_free) begin
          out_nxt.result_kind = KIND_TX;
          out_nxt.tx_byte     = emit_r[31:24];
          out_nxt.read_word   = '0;
          out_nxt.word_index  = '0;
          out_nxt.status      = ST_OK;
          out_nxt.last        = (left_r == 3'd1);
          out_valid_nxt       = 1'b1;
          emit_nxt            = {emit_r[23:0], 8'h00};
          left_nxt            = left_r - 3'd1;
          if (left_r == 3'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_nxt.result_kind = KIND_STATUS;
          out_nxt.tx_byte     = '0;
          out_nxt.read_word   = '0;
          out_nxt.word_index  = '0;
          out_nxt.status      = stat_r;
          out_nxt.last        = 1'b1;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_RFETCH: begin
        rd_en     = 1'b1;
        state_nxt = S_RWORD;
      end
      S_RWORD: begin
        if (out_free) begin
          out_nxt.result_kind = KIND_WORD;
          out_nxt.tx_byte     = '0;
          out_nxt.read_word   = rd_data;
          out_nxt.word_index  = IDX_W'(rd_idx_r);
          out_nxt.status      = ST_OK;
          out_nxt.last        = word_last;
          out_valid_nxt       = 1'b1;
          if (word_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
            state_nxt  = S_RFETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reading_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      we_r        <= '0;
      bits_r      <= '0;
      left_r      <= '0;
      high_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      reading_r   <= reading_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      we_r        <= we_nxt;
      bits_r      <= bits_nxt;
      left_r      <= left_nxt;
      high_r      <= high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sh_r     <= sh_nxt;
    emit_r   <= emit_nxt;
    stat_r   <= stat_nxt;
    final_r  <= final_nxt;
    rd_idx_r <= rd_idx_nxt;
    out_r    <= out_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_r.result_kind;
  assign out_chan.tx_byte     = out_r.tx_byte;
  assign out_chan.read_word   = out_r.read_word;
  assign out_chan.word_index  = out_r.word_index;
  assign out_chan.status      = out_r.status;
  assign out_chan.last        = out_r.last;

  // reply position never runs past the crc byte of the burst
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    reading_r |-> (pos_r <= {we_r, 1'b0}))
    else $error("reply position beyond burst length");

  // a pending read always has a legal word count
  a_we_range: assert property (@(posedge clk) disable iff (!rst_n)
    reading_r |-> ((we_r != '0) && ({1'b0, we_r} <= MAX_CNT)))
    else $error("pending read with illegal word count");

  // a write request starts the 24-bit crc pass
  a_write_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.command == CMD_WRITE)) |=> ((state_r == S_CRC) && (bits_r == 5'd24)))
    else $error("write request did not start crc pass");

  // the crc byte of a reply ends the pending read
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.command == CMD_RXBYTE) && reading_r && (pos_r == {we_r, 1'b0}))
      |=> !reading_r)
    else $error("read still pending after crc byte");

  // replay never indexes past the burst
  a_replay_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RWORD) |-> (CNT_W'(rd_idx_r) < we_r))
    else $error("replay index beyond burst");

endmodule
`default_nettype wire

FILE: sv/afe_rfe_crc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afe_rfe_crc
// Bit-serial crc-8 register, polynomial 0x07, one bit per cycle msb first while shift is set.
// ----------------------------------------------------------------------------
module afe_rfe_crc (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire afe_rfe_pkg::crc_ctl_t          ctl,
  output logic [afe_rfe_pkg::BYTE_W-1:0]      crc
);
  import afe_rfe_pkg::*;

  logic [BYTE_W-1:0] crc_r, crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clear) begin
      crc_nxt = '0;
    end else if (ctl.shift) begin
      crc_nxt = crc_bit(crc_r, ctl.din);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule
`default_nettype wire

FILE: sv/afe_rfe_wbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afe_rfe_wbuf
// Word buffer for a read burst: one write port, one registered read port.
// ----------------------------------------------------------------------------
module afe_rfe_wbuf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
